// ----- rtl/tlj_pkg.sv -----
`default_nettype none
package tlj_pkg;

  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_NL    = 8'd10;

  localparam logic [1:0] MODE_RIGHT = 2'd1;
  localparam logic [1:0] MODE_FULL  = 2'd2;

  localparam logic CFG_MODE  = 1'b0;
  localparam logic CFG_WIDTH = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_COPY,
    S_START,
    S_DIV,
    S_LEAD,
    S_RD,
    S_CHAR,
    S_PAD,
    S_NL
  } tlj_state_e;

  typedef struct packed {
    logic [7:0] in_char;
    logic       end_of_text;
  } tlj_in_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       run_last;
    logic       word_cut;
  } tlj_out_t;

  function automatic logic is_sep(input logic [7:0] c);
    return (c == CH_SPACE) || (c >= 8'd9 && c <= 8'd13);
  endfunction

endpackage
`default_nettype wire

// ----- rtl/tlj_stream_if.sv -----
`default_nettype none
interface tlj_stream_if #(parameter type word_t = logic);
  logic  valid;
  logic  ready;
  word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- rtl/tlj_ram.sv -----
`default_nettype none
module tlj_ram #(
  parameter int W = 8,
  parameter int D = 31
) (
  input  wire logic                 clk_i,
  input  wire logic                 we_i,
  input  wire logic [$clog2(D)-1:0] waddr_i,
  input  wire logic [W-1:0]         wdata_i,
  input  wire logic [$clog2(D)-1:0] raddr_i,
  output logic      [W-1:0]         rdata_o
);
  logic [W-1:0] mem [D];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

// ----- rtl/text_line_justifier.sv -----
// Timing: a byte that ends no word is taken while the block stays idle. A word commit copies the word
// store into the line store at one byte a cycle; a line emission reads each stored character
// and then emits it, emits padding spaces and the newline directly, stalls on output back-pressure,
// and in full mode first runs a 5-step gap divider. No byte is taken while a word is copied or a line emitted.
// Reset: asynchronous, active low; clears lengths, flags and config (left, width 31).
`default_nettype none
module text_line_justifier #(
  parameter int MAX_WIDTH = 31
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic       cfg_idx_i,
  input  wire logic [4:0] cfg_data_i,
  tlj_stream_if.sink      in_i,
  tlj_stream_if.source    out_o
);
  import tlj_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int LW = $clog2(MAX_WIDTH + 1);

  tlj_state_e state_q, state_d;

  logic [1:0]    mode_q;
  logic [4:0]    width_q;
  logic [LW-1:0] llen_q, llen_d, gaps_q, gaps_d, wlen_q, wlen_d;
  logic          cut_q, cut_d, eot_q, eot_d, nl_q, nl_d, app_q, app_d;
  logic [LW-1:0] k_q, k_d, gi_q, gi_d, cnt_q, cnt_d, quo_q, quo_d;
  logic [LW:0]   rem_q, rem_d;
  logic          out_valid_q;
  tlj_out_t      out_q;

  logic [LW-1:0] w_eff, ext, wlen_n, add;
  logic [LW:0]   div_sh;
  logic          acc, in_sep, store, commit, fits, can_out;
  logic          push, push_last, pad, last_idx;
  logic [7:0]    push_char, line_rdata, word_rdata;
  logic          lr_we;
  logic [AW-1:0] lr_waddr;
  logic [7:0]    lr_wdata;
  logic [LW:0]   copy_addr;

  assign w_eff  = (width_q > 5'(MAX_WIDTH)) ? LW'(MAX_WIDTH) : LW'(width_q);
  assign ext    = (llen_q < w_eff) ? w_eff - llen_q : '0;
  assign in_sep = is_sep(in_i.data.in_char);
  assign acc    = in_i.valid && in_i.ready;
  assign store  = !in_sep && (wlen_q < LW'(MAX_WIDTH));
  assign wlen_n = wlen_q + LW'(store);
  assign commit = (in_sep || in_i.data.end_of_text) && (wlen_n != '0);
  assign fits   = (llen_q != '0) &&
                  (({1'b0, llen_q} + (LW+1)'(1) + {1'b0, wlen_n}) <= {1'b0, w_eff});
  assign can_out = !out_valid_q || out_o.ready;
  assign pad     = (mode_q == MODE_FULL) && (gaps_q != '0) && (line_rdata == CH_SPACE);
  assign add     = quo_q + LW'(({1'b0, gi_q} < rem_q));
  assign last_idx = (k_q + LW'(1)) == llen_q;
  assign div_sh  = {rem_q[LW-1:0], quo_q[LW-1]};
  assign copy_addr = app_q ? ({1'b0, llen_q} + {1'b0, k_q}) : ({1'b0, k_q} - (LW+1)'(1));

  assign in_i.ready  = (state_q == S_IDLE);
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  tlj_ram #(.W(8), .D(MAX_WIDTH)) u_word_ram (
    .clk_i  (clk_i),
    .we_i   (acc && store),
    .waddr_i(wlen_q[AW-1:0]),
    .wdata_i(in_i.data.in_char),
    .raddr_i(k_q[AW-1:0]),
    .rdata_o(word_rdata)
  );

  tlj_ram #(.W(8), .D(MAX_WIDTH)) u_line_ram (
    .clk_i  (clk_i),
    .we_i   (lr_we),
    .waddr_i(lr_waddr),
    .wdata_i(lr_wdata),
    .raddr_i(k_q[AW-1:0]),
    .rdata_o(line_rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (acc) begin
          if (commit) begin
            state_d = (!fits && llen_q != '0) ? S_START : S_COPY;
          end else if (in_i.data.end_of_text && llen_q != '0) begin
            state_d = S_START;
          end
        end
      end
      S_COPY: begin
        if (k_q == wlen_q) begin
          state_d = eot_q ? S_START : S_IDLE;
        end
      end
      S_START: begin
        if (mode_q == MODE_FULL && gaps_q != '0) begin
          state_d = S_DIV;
        end else if (mode_q == MODE_RIGHT && ext != '0) begin
          state_d = S_LEAD;
        end else begin
          state_d = S_RD;
        end
      end
      S_DIV: begin
        if (cnt_q == LW'(1)) begin
          state_d = S_RD;
        end
      end
      S_LEAD, S_PAD: begin
        if (can_out && cnt_q == LW'(1)) begin
          state_d = S_RD;
        end
      end
      S_RD: state_d = S_CHAR;
      S_CHAR: begin
        if (can_out) begin
          if (pad && add != '0) begin
            state_d = S_PAD;
          end else if (!last_idx) begin
            state_d = S_RD;
          end else begin
            state_d = nl_q ? S_NL : S_IDLE;
          end
        end
      end
      S_NL: begin
        if (can_out) begin
          state_d = S_COPY;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    llen_d = llen_q;
    gaps_d = gaps_q;
    wlen_d = wlen_q;
    cut_d  = cut_q;
    eot_d  = eot_q;
    nl_d   = nl_q;
    app_d  = app_q;
    k_d    = k_q;
    gi_d   = gi_q;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    push      = 1'b0;
    push_last = 1'b0;
    push_char = CH_SPACE;
    lr_we     = 1'b0;
    lr_waddr  = copy_addr[AW-1:0];
    lr_wdata  = word_rdata;
    unique case (state_q)
      S_IDLE: begin
        if (acc) begin
          wlen_d = wlen_n;
          eot_d  = in_i.data.end_of_text;
          app_d  = fits;
          nl_d   = commit && !fits && (llen_q != '0);
          k_d    = '0;
          if (!in_sep && !store) begin
            cut_d = 1'b1;
          end
          if (!commit && in_i.data.end_of_text && llen_q == '0) begin
            llen_d = '0;
            gaps_d = '0;
            wlen_d = '0;
            cut_d  = 1'b0;
          end
        end
      end
      S_COPY: begin
        k_d = k_q + LW'(1);
        if (k_q == '0) begin
          lr_we    = app_q;
          lr_waddr = llen_q[AW-1:0];
          lr_wdata = CH_SPACE;
        end else begin
          lr_we = 1'b1;
        end
        if (k_q == wlen_q) begin
          llen_d = app_q ? llen_q + wlen_q + LW'(1) : wlen_q;
          gaps_d = app_q ? gaps_q + LW'(1) : '0;
          wlen_d = '0;
          nl_d   = 1'b0;
          k_d    = '0;
        end
      end
      S_START: begin
        k_d  = '0;
        gi_d = '0;
        if (mode_q == MODE_FULL && gaps_q != '0) begin
          cnt_d = LW'(LW);
          rem_d = '0;
          quo_d = ext;
        end else begin
          cnt_d = ext;
        end
      end
      S_DIV: begin
        cnt_d = cnt_q - LW'(1);
        if (div_sh >= {1'b0, gaps_q}) begin
          rem_d = div_sh - {1'b0, gaps_q};
          quo_d = {quo_q[LW-2:0], 1'b1};
        end else begin
          rem_d = div_sh;
          quo_d = {quo_q[LW-2:0], 1'b0};
        end
      end
      S_LEAD, S_PAD: begin
        if (can_out) begin
          push  = 1'b1;
          cnt_d = cnt_q - LW'(1);
        end
      end
      S_RD: ;
      S_CHAR: begin
        if (can_out) begin
          push      = 1'b1;
          push_char = line_rdata;
          push_last = !(pad && add != '0) && last_idx && !nl_q;
          if (pad) begin
            gi_d  = gi_q + LW'(1);
            cnt_d = add;
          end
          k_d = k_q + LW'(1);
          if (!(pad && add != '0) && last_idx) begin
            k_d = '0;
            if (!nl_q) begin
              llen_d = '0;
              gaps_d = '0;
              wlen_d = '0;
              cut_d  = 1'b0;
            end
          end
        end
      end
      S_NL: begin
        if (can_out) begin
          push      = 1'b1;
          push_char = CH_NL;
          push_last = !eot_q;
          app_d     = 1'b0;
          k_d       = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mode_q      <= 2'd0;
      width_q     <= 5'd31;
      llen_q      <= '0;
      gaps_q      <= '0;
      wlen_q      <= '0;
      cut_q       <= 1'b0;
      eot_q       <= 1'b0;
      nl_q        <= 1'b0;
      app_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      llen_q  <= llen_d;
      gaps_q  <= gaps_d;
      wlen_q  <= wlen_d;
      cut_q   <= cut_d;
      eot_q   <= eot_d;
      nl_q    <= nl_d;
      app_q   <= app_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_MODE:  mode_q  <= cfg_data_i[1:0];
          CFG_WIDTH: width_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (push) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    k_q   <= k_d;
    gi_q  <= gi_d;
    cnt_q <= cnt_d;
    quo_q <= quo_d;
    rem_q <= rem_d;
    if (push) begin
      out_q <= '{out_char: push_char, run_last: push_last, word_cut: cut_q};
    end
  end
endmodule
`default_nettype wire

// ----- rtl/tlj_checker.sv -----
`default_nettype none
module tlj_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_char,
  input wire logic       run_last,
  input wire logic       word_cut
);
  // a run never ends on a padding or gap space
  a_last_not_space: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && run_last |-> out_char != 8'd32) else $error("run ends on space");

  // while a run is still being emitted no new byte is taken
  a_busy_no_intake: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !run_last |-> !in_ready) else $error("intake during emission");

  a_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid) else $error("valid dropped");

  a_data_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> $stable({out_char, run_last, word_cut}))
    else $error("stalled word changed");
endmodule

bind text_line_justifier tlj_checker u_tlj_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .in_ready (in_i.ready),
  .out_valid(out_o.valid),
  .out_ready(out_o.ready),
  .out_char (out_o.data.out_char),
  .run_last (out_o.data.run_last),
  .word_cut (out_o.data.word_cut)
);
`default_nettype wire

// ----- dv/testbench.sv -----
`default_nettype none
module testbench;
  import tlj_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_we_i = 1'b0;
  logic       cfg_idx_i = CFG_MODE;
  logic [4:0] cfg_data_i = '0;

  tlj_stream_if #(.word_t(tlj_in_t))  text_in ();
  tlj_stream_if #(.word_t(tlj_out_t)) text_out ();

  text_line_justifier i_dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i), .in_i(text_in.sink), .out_o(text_out.source)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  localparam int unsigned WMAX = 31;

  // predictor state
  logic [7:0] line_buf [WMAX];
  logic [7:0] word_buf [WMAX];
  int unsigned line_len, gaps, word_len;
  logic        cut_seen;
  logic [1:0]  mode_reg = 2'd0;
  logic [4:0]  width_reg = 5'd31;

  tlj_out_t expected_bytes[$];
  int unsigned errors = 0;
  bit quiet = 1'b0;

  function automatic void push_byte(logic [7:0] c);
    tlj_out_t r;
    r.out_char = c;
    r.run_last = 1'b0;
    r.word_cut = cut_seen;
    expected_bytes = {expected_bytes, r};
  endfunction

  function automatic void emit_line(bit with_nl);
    int unsigned w, len, extra, gi, add;
    w = width_reg;
    len = line_len > WMAX ? WMAX : line_len;
    extra = len < w ? w - len : 0;
    gi = 0;
    if (mode_reg == MODE_RIGHT)
      repeat (extra) push_byte(CH_SPACE);
    for (int unsigned i = 0; i < len; i++) begin
      push_byte(line_buf[i]);
      if (mode_reg == MODE_FULL && gaps > 0 && line_buf[i] == CH_SPACE) begin
        add = extra / gaps + ((gi < extra % gaps) ? 1 : 0);
        repeat (add) push_byte(CH_SPACE);
        gi++;
      end
    end
    if (with_nl) push_byte(CH_NL);
  endfunction

  function automatic void commit_word();
    if (word_len == 0) return;
    if (line_len > 0 && line_len + 1 + word_len <= width_reg) begin
      line_buf[line_len] = CH_SPACE;
      for (int unsigned i = 0; i < word_len; i++) line_buf[line_len + 1 + i] = word_buf[i];
      line_len += 1 + word_len;
      gaps++;
    end else begin
      if (line_len > 0) emit_line(1'b1);
      for (int unsigned i = 0; i < word_len; i++) line_buf[i] = word_buf[i];
      line_len = word_len;
      gaps = 0;
    end
    word_len = 0;
  endfunction

  function automatic void predict_text(tlj_in_t it);
    int n0;
    bit sep;
    n0 = expected_bytes.size();
    sep = (it.in_char == CH_SPACE) || (it.in_char >= 8'd9 && it.in_char <= 8'd13);
    if (!sep) begin
      if (word_len < WMAX) begin
        word_buf[word_len] = it.in_char;
        word_len++;
      end else cut_seen = 1'b1;
    end
    if (sep || it.end_of_text) commit_word();
    if (it.end_of_text) begin
      if (line_len > 0) emit_line(1'b0);
      line_len = 0; gaps = 0; word_len = 0; cut_seen = 1'b0;
    end
    if (expected_bytes.size() > n0)
      expected_bytes[expected_bytes.size() - 1].run_last = 1'b1;
  endfunction

  // sender; valid stays up between back-to-back bytes unless a random idle gap drops it, drain() drops it
  task automatic send_byte(logic [7:0] c, logic eot);
    tlj_in_t it;
    it.in_char = c;
    it.end_of_text = eot;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      text_in.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    text_in.valid <= 1'b1;
    text_in.data <= it;
    do @(posedge clk_i); while (!text_in.ready);
    predict_text(it);
  endtask

  // receiver stalls
  initial begin
    text_out.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (!quiet && $urandom_range(0, 5) == 0) begin
        text_out.ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk_i);
      end
      text_out.ready <= 1'b1;
    end
  end

  // result check
  always @(posedge clk_i) begin
    if (rst_ni && text_out.valid && text_out.ready) begin
      if (expected_bytes.size() == 0) begin
        errors++;
        $display("%0t unexpected byte: expected none, actual %p", $time, text_out.data);
      end else begin
        tlj_out_t e;
        e = expected_bytes.pop_front();
        if (e.out_char != text_out.data.out_char) begin
          errors++;
          $display("%0t out_char: expected %0d, actual %0d", $time, e.out_char,
                   text_out.data.out_char);
        end
        if (e.run_last != text_out.data.run_last) begin
          errors++;
          $display("%0t run_last: expected %0b, actual %0b", $time, e.run_last,
                   text_out.data.run_last);
        end
        if (e.word_cut != text_out.data.word_cut) begin
          errors++;
          $display("%0t word_cut: expected %0b, actual %0b", $time, e.word_cut,
                   text_out.data.word_cut);
        end
      end
    end
  end

  task automatic drain();
    text_in.valid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [4:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_MODE) mode_reg = (val[1:0] == 2'd3) ? 2'd0 : val[1:0];
    else width_reg = val;
    @(posedge clk_i);
  endtask

  function automatic logic [7:0] rand_letter();
    return 8'($urandom_range(97, 122));
  endfunction

  function automatic logic [7:0] rand_sep();
    case ($urandom_range(0, 3))
      0: return 8'd9;
      1: return 8'($urandom_range(10, 13));
      default: return CH_SPACE;
    endcase
  endfunction

  task automatic send_word(int unsigned len);
    repeat (len) send_byte(rand_letter(), 1'b0);
  endtask

  task automatic test_directed();
    // empty text, full-range bytes, separators, overlong word
    send_byte(CH_SPACE, 1'b1);
    send_byte(8'd255, 1'b0);
    send_byte(8'd0, 1'b0);
    send_byte(8'd128, 1'b0);
    send_byte(8'd9, 1'b0);
    send_byte(8'd127, 1'b0);
    send_byte(8'd13, 1'b0);
    send_byte(8'd14, 1'b0);
    send_byte(8'd8, 1'b1);
    drain();
    send_word(34);
    send_byte(CH_SPACE, 1'b0);
    send_word(3);
    send_byte(8'd33, 1'b1);
    drain();
  endtask

  // words are mostly short; a few longer than the line or the store
  task automatic test_random_text(int unsigned n_bytes);
    int unsigned sent;
    int unsigned len;
    sent = 0;
    while (sent < n_bytes) begin
      case ($urandom_range(0, 19))
        0: len = $urandom_range(20, 35);
        1: begin
          send_byte(8'($urandom_range(0, 255)), 1'b0);
          sent++;
          len = 0;
        end
        default: len = $urandom_range(1, 7);
      endcase
      send_word(len);
      sent += len;
      if ($urandom_range(0, 9) == 0) begin
        send_byte(rand_sep(), 1'b0);
        sent++;
      end
      if ($urandom_range(0, 7) == 0 || sent >= n_bytes) begin
        send_byte($urandom_range(0, 1) ? rand_letter() : rand_sep(), 1'b1);
        sent++;
      end else begin
        send_byte(rand_sep(), 1'b0);
        sent++;
      end
    end
    drain();
  endtask

  task automatic test_settings();
    logic [4:0] widths [6];
    widths = '{5'd31, 5'd1, 5'd0, 5'd10, 5'd6, 5'd17};
    for (int m = 0; m < 4; m++) begin
      write_reg(CFG_MODE, 5'(m) | 5'($urandom_range(0, 7) << 2));
      for (int k = 0; k < 6; k++) begin
        write_reg(CFG_WIDTH, widths[k]);
        test_random_text(m == 3 ? 4 : 5);
      end
    end
  endtask

  initial begin
    text_in.valid = 1'b0;
    text_in.data = '0;
    line_len = 0; gaps = 0; word_len = 0; cut_seen = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_settings();
    quiet = 1'b1;
    write_reg(CFG_MODE, MODE_FULL);
    write_reg(CFG_WIDTH, 5'd12);
    test_random_text(20);
    if (errors == 0) $display("testbench: clean");
    else $display("testbench: errors");
    $finish;
  end

  initial begin
    #40ms;
    $display("testbench: errors");
    $finish;
  end
endmodule
`default_nettype wire
